// ===== hdl/aescbc_pkg.sv =====
package aescbc_pkg;

    localparam int ROUNDS_DEF = 10;
    localparam int RND_W      = 4;
    localparam int BLK_W      = 128;
    localparam int HALF_W     = 64;
    localparam int CNT_W      = 5;
    localparam int IDX_W      = 3;
    localparam int TDATA_W    = 136;
    localparam int TUSER_W    = 2;

    // register indexes of the configuration port
    localparam logic [IDX_W-1:0] REG_KEY_HIGH = 3'd0;
    localparam logic [IDX_W-1:0] REG_KEY_LOW  = 3'd1;
    localparam logic [IDX_W-1:0] REG_IV_HIGH  = 3'd2;
    localparam logic [IDX_W-1:0] REG_IV_LOW   = 3'd3;
    localparam logic [IDX_W-1:0] REG_DIR      = 3'd4;
    localparam logic [IDX_W-1:0] REG_PAD      = 3'd5;

    // result status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_PARTIAL = 2'd1;
    localparam logic [1:0] ST_BAD_PAD = 2'd2;
    localparam logic [1:0] ST_PART_CT = 2'd3;

    localparam logic DIR_ENC = 1'b0;

    typedef enum logic [1:0] {
        ST_EXPAND,
        ST_IDLE,
        ST_ROUND,
        ST_FINISH
    } ctrl_state_t;

    typedef struct packed {
        logic             load;
        logic             round_en;
        logic             final_rnd;
        logic             emit;
        logic             extra_load;
        logic             exp_step;
        logic             pass2;
        logic [RND_W-1:0] rnd;
    } cmd_t;

    typedef struct packed {
        logic key_wr;
        logic in_err;
        logic extra;
        logic out_free;
    } stat_t;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    function automatic logic [7:0] sbox(input logic [7:0] b);
        return SBOX[b];
    endfunction

    // inverse affine map of the S-box
    function automatic logic [7:0] aff_inv(input logic [7:0] b);
        return {b[6:0], b[7]} ^ {b[4:0], b[7:5]} ^ {b[1:0], b[7:2]} ^ 8'h05;
    endfunction

    // inverse S-box through the forward table: field inverse is an involution
    function automatic logic [7:0] inv_sbox(input logic [7:0] b);
        return aff_inv(sbox(aff_inv(b)));
    endfunction

    function automatic logic [7:0] xt(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [7:0] rcon(input logic [RND_W-1:0] idx);
        logic [7:0] r;
        case (idx)
            4'd1:    r = 8'h01;
            4'd2:    r = 8'h02;
            4'd3:    r = 8'h04;
            4'd4:    r = 8'h08;
            4'd5:    r = 8'h10;
            4'd6:    r = 8'h20;
            4'd7:    r = 8'h40;
            4'd8:    r = 8'h80;
            4'd9:    r = 8'h1b;
            4'd10:   r = 8'h36;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    function automatic logic [31:0] sub_rot(input logic [31:0] w, input logic [7:0] rc);
        return {sbox(w[23:16]) ^ rc, sbox(w[15:8]), sbox(w[7:0]), sbox(w[31:24])};
    endfunction

    // next round key from the current one
    function automatic logic [BLK_W-1:0] key_fwd(input logic [BLK_W-1:0] k,
                                                 input logic [7:0] rc);
        logic [31:0] w0, w1, w2, w3;
        w0 = k[127:96] ^ sub_rot(k[31:0], rc);
        w1 = k[95:64] ^ w0;
        w2 = k[63:32] ^ w1;
        w3 = k[31:0] ^ w2;
        return {w0, w1, w2, w3};
    endfunction

    // previous round key from the current one
    function automatic logic [BLK_W-1:0] key_inv(input logic [BLK_W-1:0] k,
                                                 input logic [7:0] rc);
        logic [31:0] w1, w2, w3;
        w3 = k[31:0] ^ k[63:32];
        w2 = k[63:32] ^ k[95:64];
        w1 = k[95:64] ^ k[127:96];
        return {k[127:96] ^ sub_rot(w3, rc), w1, w2, w3};
    endfunction

    function automatic logic [BLK_W-1:0] enc_round(input logic [BLK_W-1:0] s,
                                                   input logic [BLK_W-1:0] k,
                                                   input logic fin);
        logic [7:0] t [16];
        logic [7:0] q [16];
        logic [7:0] all;
        logic [BLK_W-1:0] o;
        for (int i = 0; i < 16; i++) begin
            t[i] = sbox(s[BLK_W-1-8*((i & 3) + 4*(((i >> 2) + (i & 3)) & 3)) -: 8]);
        end
        for (int c = 0; c < 4; c++) begin
            all = t[4*c] ^ t[4*c+1] ^ t[4*c+2] ^ t[4*c+3];
            for (int r = 0; r < 4; r++) begin
                q[4*c+r] = fin ? t[4*c+r]
                         : t[4*c+r] ^ all ^ xt(t[4*c+r] ^ t[4*c+((r+1) & 3)]);
            end
        end
        for (int i = 0; i < 16; i++) begin
            o[BLK_W-1-8*i -: 8] = q[i];
        end
        return o ^ k;
    endfunction

    function automatic logic [BLK_W-1:0] dec_round(input logic [BLK_W-1:0] s,
                                                   input logic [BLK_W-1:0] k,
                                                   input logic fin);
        logic [7:0] x [16];
        logic [7:0] a [4];
        logic [7:0] m2 [4];
        logic [7:0] m4 [4];
        logic [7:0] m8 [4];
        logic [BLK_W-1:0] o;
        for (int i = 0; i < 16; i++) begin
            x[i] = inv_sbox(s[BLK_W-1-8*((i & 3) + 4*(((i >> 2) + 4 - (i & 3)) & 3)) -: 8])
                 ^ k[BLK_W-1-8*i -: 8];
        end
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                a[r]  = x[4*c+r];
                m2[r] = xt(a[r]);
                m4[r] = xt(m2[r]);
                m8[r] = xt(m4[r]);
            end
            for (int r = 0; r < 4; r++) begin
                // 14, 11, 13, 9 rotated along the column
                o[BLK_W-1-8*(4*c+r) -: 8] = fin ? x[4*c+r]
                    : (m8[r] ^ m4[r] ^ m2[r])
                    ^ (m8[(r+1)&3] ^ m2[(r+1)&3] ^ a[(r+1)&3])
                    ^ (m8[(r+2)&3] ^ m4[(r+2)&3] ^ a[(r+2)&3])
                    ^ (m8[(r+3)&3] ^ a[(r+3)&3]);
            end
        end
        return o;
    endfunction

endpackage

// ===== hdl/aescbc_ctrl.sv =====
module aescbc_ctrl
    import aescbc_pkg::*;
#(
    parameter int ROUNDS = ROUNDS_DEF
) (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  s_tvalid,
    output logic  s_tready,
    input  stat_t stat,
    output cmd_t  cmd
);

    localparam logic [RND_W-1:0] RND_LAST = RND_W'(ROUNDS);

    ctrl_state_t      state_reg, state_next;
    logic [RND_W-1:0] rnd_reg, rnd_next;
    logic             pass2_reg, pass2_next;

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_EXPAND;
            rnd_reg   <= RND_W'(1);
            pass2_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            rnd_reg   <= rnd_next;
            pass2_reg <= pass2_next;
        end
    end

    // next state and commands
    always_comb begin
        state_next = state_reg;
        rnd_next   = rnd_reg;
        pass2_next = pass2_reg;
        s_tready   = 1'b0;
        cmd        = '0;
        cmd.rnd       = rnd_reg;
        cmd.pass2     = pass2_reg;
        cmd.final_rnd = (rnd_reg == RND_LAST);
        case (state_reg)
            ST_EXPAND: begin
                cmd.exp_step = 1'b1;
                if (stat.key_wr) begin
                    rnd_next = RND_W'(1);
                end else if (rnd_reg == RND_LAST) begin
                    state_next = ST_IDLE;
                end else begin
                    rnd_next = rnd_reg + RND_W'(1);
                end
            end
            ST_IDLE: begin
                // hold off input words while a key write restarts the expansion
                s_tready = !stat.key_wr;
                if (stat.key_wr) begin
                    state_next = ST_EXPAND;
                    rnd_next   = RND_W'(1);
                end else if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    pass2_next = 1'b0;
                    rnd_next   = RND_W'(1);
                    state_next = stat.in_err ? ST_FINISH : ST_ROUND;
                end
            end
            ST_ROUND: begin
                cmd.round_en = 1'b1;
                if (rnd_reg == RND_LAST) begin
                    state_next = ST_FINISH;
                end else begin
                    rnd_next = rnd_reg + RND_W'(1);
                end
            end
            ST_FINISH: begin
                if (stat.out_free) begin
                    cmd.emit = 1'b1;
                    if (stat.extra && !pass2_reg) begin
                        // padding-only block follows a full last block
                        cmd.extra_load = 1'b1;
                        pass2_next     = 1'b1;
                        rnd_next       = RND_W'(1);
                        state_next     = ST_ROUND;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule

// ===== hdl/aescbc_dp.sv =====
module aescbc_dp
    import aescbc_pkg::*;
#(
    parameter int ROUNDS = ROUNDS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_valid,
    input  logic [IDX_W-1:0]     cfg_index,
    input  logic [HALF_W-1:0]    cfg_data,
    input  logic                 s_accept,
    input  logic [TDATA_W-1:0]   s_tdata,
    input  logic                 s_tlast,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [TDATA_W-1:0]   m_tdata,
    output logic                 m_tlast,
    output logic [TUSER_W-1:0]   m_tuser,
    input  cmd_t                 cmd,
    output stat_t                stat
);

    localparam logic [RND_W-1:0] RND_LAST = RND_W'(ROUNDS);

    logic [HALF_W-1:0] key_high_reg, key_low_reg, iv_high_reg, iv_low_reg;
    logic              dir_reg, pad_reg;
    logic              msg_start_reg;
    logic [BLK_W-1:0]  kx_reg, rk_reg, state_reg, chain_reg, pchain_reg;
    logic [1:0]        err_reg;
    logic              extra_reg, last_reg;
    logic              out_valid_reg;
    logic [BLK_W-1:0]  out_blk_reg;
    logic [CNT_W-1:0]  out_vb_reg;
    logic              out_eom_reg;
    logic [1:0]        out_st_reg;

    logic [BLK_W-1:0]  key, blk_in, chain_eff, padded, x, stripped;
    logic [CNT_W-1:0]  cnt;
    logic [1:0]        in_err;
    logic              in_extra;
    logic [7:0]        pad_n;
    logic              pad_ok;
    logic [BLK_W-1:0]  res_blk;
    logic [CNT_W-1:0]  res_vb;
    logic              res_eom;
    logic [1:0]        res_st;

    assign key       = {key_high_reg, key_low_reg};
    assign blk_in    = {s_tdata[63:0], s_tdata[127:64]};
    assign chain_eff = msg_start_reg ? {iv_high_reg, iv_low_reg} : chain_reg;
    assign cnt       = (s_tdata[132:128] > CNT_W'(16)) ? CNT_W'(16) : s_tdata[132:128];

    // classify the incoming word
    always_comb begin
        in_err   = ST_OK;
        in_extra = 1'b0;
        if (dir_reg == DIR_ENC) begin
            if (cnt < CNT_W'(16) && (!s_tlast || !pad_reg)) begin
                in_err = ST_PARTIAL;
            end
            in_extra = s_tlast && pad_reg && (cnt == CNT_W'(16));
        end else if (cnt != CNT_W'(16)) begin
            in_err = ST_PART_CT;
        end
    end

    // fill the tail of a short block with the pad count
    always_comb begin
        for (int i = 0; i < 16; i++) begin
            padded[BLK_W-1-8*i -: 8] = (CNT_W'(i) < cnt) ? blk_in[BLK_W-1-8*i -: 8]
                                     : 8'(CNT_W'(16) - cnt);
        end
    end

    // padding check and strip on the deciphered block
    assign x     = state_reg ^ pchain_reg;
    assign pad_n = x[7:0];
    always_comb begin
        pad_ok = (pad_n >= 8'd1) && (pad_n <= 8'd16);
        for (int i = 0; i < 16; i++) begin
            if (8'(16 - i) <= pad_n) begin
                stripped[BLK_W-1-8*i -: 8] = 8'h00;
                if (x[BLK_W-1-8*i -: 8] != pad_n) begin
                    pad_ok = 1'b0;
                end
            end else begin
                stripped[BLK_W-1-8*i -: 8] = x[BLK_W-1-8*i -: 8];
            end
        end
    end

    // select the result word
    always_comb begin
        res_blk = '0;
        res_vb  = '0;
        res_eom = 1'b1;
        res_st  = err_reg;
        if (err_reg != ST_OK) begin
            res_st = err_reg;
        end else if (dir_reg == DIR_ENC) begin
            res_blk = state_reg;
            res_vb  = CNT_W'(16);
            res_eom = last_reg && (!extra_reg || cmd.pass2);
        end else if (last_reg && pad_reg) begin
            if (pad_ok) begin
                res_blk = stripped;
                res_vb  = CNT_W'(16) - pad_n[CNT_W-1:0];
                res_st  = ST_OK;
            end else begin
                res_st  = ST_BAD_PAD;
            end
        end else begin
            res_blk = x;
            res_vb  = CNT_W'(16);
            res_eom = last_reg;
        end
    end

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_high_reg <= '0;
            key_low_reg  <= '0;
            iv_high_reg  <= '0;
            iv_low_reg   <= '0;
            dir_reg      <= DIR_ENC;
            pad_reg      <= 1'b1;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_KEY_HIGH: key_high_reg <= cfg_data;
                REG_KEY_LOW:  key_low_reg  <= cfg_data;
                REG_IV_HIGH:  iv_high_reg  <= cfg_data;
                REG_IV_LOW:   iv_low_reg   <= cfg_data;
                REG_DIR:      dir_reg      <= cfg_data[0];
                REG_PAD:      pad_reg      <= cfg_data[0];
                default:      ;
            endcase
        end
    end

    // key expansion to the last round key
    always_ff @(posedge aclk) begin
        if (cmd.exp_step) begin
            kx_reg <= key_fwd((cmd.rnd == RND_W'(1)) ? key : kx_reg, rcon(cmd.rnd));
        end
    end

    // cipher state, running round key and chain
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            err_reg   <= in_err;
            extra_reg <= in_extra && (in_err == ST_OK);
            last_reg  <= s_tlast;
            if (dir_reg == DIR_ENC) begin
                state_reg <= padded ^ chain_eff ^ key;
                rk_reg    <= key_fwd(key, rcon(RND_W'(1)));
            end else begin
                state_reg  <= blk_in ^ kx_reg;
                rk_reg     <= key_inv(kx_reg, rcon(RND_LAST));
                pchain_reg <= chain_eff;
                chain_reg  <= blk_in;
            end
        end else if (cmd.round_en) begin
            if (dir_reg == DIR_ENC) begin
                state_reg <= enc_round(state_reg, rk_reg, cmd.final_rnd);
                rk_reg    <= key_fwd(rk_reg, rcon(cmd.rnd + RND_W'(1)));
            end else begin
                state_reg <= dec_round(state_reg, rk_reg, cmd.final_rnd);
                rk_reg    <= key_inv(rk_reg, rcon(RND_LAST - cmd.rnd));
            end
        end else if (cmd.emit) begin
            if (dir_reg == DIR_ENC && err_reg == ST_OK) begin
                chain_reg <= state_reg;
            end
            if (cmd.extra_load) begin
                state_reg <= {16{8'h10}} ^ state_reg ^ key;
                rk_reg    <= key_fwd(key, rcon(RND_W'(1)));
            end
        end
    end

    // message start flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            msg_start_reg <= 1'b1;
        end else if (cmd.load) begin
            msg_start_reg <= 1'b0;
        end else if (cmd.emit && res_eom) begin
            msg_start_reg <= 1'b1;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            out_blk_reg <= res_blk;
            out_vb_reg  <= res_vb;
            out_eom_reg <= res_eom;
            out_st_reg  <= res_st;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, out_vb_reg, out_blk_reg[63:0], out_blk_reg[127:64]};
    assign m_tlast  = out_eom_reg;
    assign m_tuser  = out_st_reg;

    assign stat.key_wr   = cfg_valid && (cfg_index == REG_KEY_HIGH || cfg_index == REG_KEY_LOW);
    assign stat.in_err   = (in_err != ST_OK) && s_accept;
    assign stat.extra    = extra_reg;
    assign stat.out_free = !out_valid_reg || m_tready;

endmodule

// ===== hdl/aes128_cbc_engine.sv =====
// An accepted block is loaded, runs ten rounds of the single round unit, then waits in
// finish until the output register is free; an error result skips the rounds.
// No new block is taken until finish is done, nor before the pad block of a last block.
// Reset and a key write in idle or expansion start the key expansion; no word is taken meanwhile.
// Reset is synchronous, active low: key and IV clear, encrypt, padding on.
module aes128_cbc_engine
    import aescbc_pkg::*;
#(
    parameter int ROUNDS = ROUNDS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [IDX_W-1:0]    cfg_index,
    input  logic [HALF_W-1:0]   cfg_data,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [TDATA_W-1:0]  s_tdata,   // data_high, data_low, byte_count, zero fill
    input  logic                s_tlast,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [TDATA_W-1:0]  m_tdata,   // result_high, result_low, valid_bytes, zero fill
    output logic                m_tlast,
    output logic [TUSER_W-1:0]  m_tuser    // status
);

    cmd_t  cmd;
    stat_t stat;

    assign cfg_ready = 1'b1;

    aescbc_ctrl #(
        .ROUNDS (ROUNDS)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    aescbc_dp #(
        .ROUNDS (ROUNDS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_accept  (s_tvalid && s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule

// ===== dv/aes128_cbc_engine_tb.sv =====
`timescale 1ns / 100ps

module aes128_cbc_engine_tb;
    import aescbc_pkg::*;

    typedef struct {
        logic [63:0] hi;
        logic [63:0] lo;
        logic [4:0]  cnt;
        logic        is_last;
    } blk_word_t;

    typedef struct {
        logic [63:0] hi;
        logic [63:0] lo;
        logic [4:0]  vb;
        logic        eom;
        logic [1:0]  st;
    } res_word_t;

    logic               aclk;
    logic               aresetn;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [IDX_W-1:0]   cfg_index;
    logic [HALF_W-1:0]  cfg_data;
    logic               s_tvalid;
    logic               s_tready;
    logic [TDATA_W-1:0] s_tdata;
    logic               s_tlast;
    logic               m_tvalid;
    logic               m_tready;
    logic [TDATA_W-1:0] m_tdata;
    logic               m_tlast;
    logic [TUSER_W-1:0] m_tuser;

    aes128_cbc_engine DUT (.*);

    // predictor copy of registers and chaining state
    logic [63:0]  key_hi, key_lo, iv_hi, iv_lo;
    logic         dir_dec, pad_on, new_msg;
    logic [127:0] chain;
    logic [127:0] rkey [11];
    logic [7:0]   inv_sb [256];

    blk_word_t pending_words [$];
    res_word_t expected_res [$];
    blk_word_t cur_word;
    bit        s_taken;
    bit        calm;
    int        s_gap, m_gap;
    int        n_fail, n_words, n_res, n_phase;

    always begin
        aclk = 1'b1;
        #4;
        aclk = 1'b0;
        #4;
    end

    function automatic logic [7:0] gm(input logic [7:0] a, input int m);
        logic [7:0] r;
        r = 8'h00;
        while (m != 0) begin
            if (m & 1) r ^= a;
            a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
            m >>= 1;
        end
        return r;
    endfunction

    // rebuild the eleven round keys from the key registers
    function automatic void expand_keys();
        logic [31:0] w [44];
        logic [31:0] t;
        logic [7:0]  rc;
        rc = 8'h01;
        {w[0], w[1], w[2], w[3]} = {key_hi, key_lo};
        for (int i = 4; i < 44; i++) begin
            t = w[i-1];
            if (i % 4 == 0) begin
                t = {SBOX[t[23:16]] ^ rc, SBOX[t[15:8]], SBOX[t[7:0]], SBOX[t[31:24]]};
                rc = gm(rc, 2);
            end
            w[i] = w[i-4] ^ t;
        end
        for (int r = 0; r < 11; r++) rkey[r] = {w[4*r], w[4*r+1], w[4*r+2], w[4*r+3]};
    endfunction

    function automatic logic [127:0] cipher_fwd(input logic [127:0] x);
        logic [7:0] s [16];
        logic [7:0] t [16];
        logic [7:0] a0, a1, a2, a3, al;
        logic [127:0] o;
        for (int i = 0; i < 16; i++) s[i] = x[127-8*i -: 8] ^ rkey[0][127-8*i -: 8];
        for (int r = 1; r <= 10; r++) begin
            for (int i = 0; i < 16; i++) t[i] = SBOX[s[(i & 3) + 4*(((i >> 2) + (i & 3)) & 3)]];
            if (r != 10) begin
                for (int c = 0; c < 4; c++) begin
                    a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
                    al = a0 ^ a1 ^ a2 ^ a3;
                    t[4*c]   = a0 ^ al ^ gm(a0 ^ a1, 2);
                    t[4*c+1] = a1 ^ al ^ gm(a1 ^ a2, 2);
                    t[4*c+2] = a2 ^ al ^ gm(a2 ^ a3, 2);
                    t[4*c+3] = a3 ^ al ^ gm(a3 ^ a0, 2);
                end
            end
            for (int i = 0; i < 16; i++) s[i] = t[i] ^ rkey[r][127-8*i -: 8];
        end
        for (int i = 0; i < 16; i++) o[127-8*i -: 8] = s[i];
        return o;
    endfunction

    function automatic logic [127:0] cipher_inv(input logic [127:0] x);
        logic [7:0] s [16];
        logic [7:0] t [16];
        logic [7:0] a0, a1, a2, a3;
        logic [127:0] o;
        for (int i = 0; i < 16; i++) s[i] = x[127-8*i -: 8] ^ rkey[10][127-8*i -: 8];
        for (int r = 9; r >= 0; r--) begin
            for (int i = 0; i < 16; i++) t[(i & 3) + 4*(((i >> 2) + (i & 3)) & 3)] = inv_sb[s[i]];
            for (int i = 0; i < 16; i++) s[i] = t[i] ^ rkey[r][127-8*i -: 8];
            if (r != 0) begin
                for (int c = 0; c < 4; c++) begin
                    a0 = s[4*c]; a1 = s[4*c+1]; a2 = s[4*c+2]; a3 = s[4*c+3];
                    s[4*c]   = gm(a0, 14) ^ gm(a1, 11) ^ gm(a2, 13) ^ gm(a3, 9);
                    s[4*c+1] = gm(a0, 9) ^ gm(a1, 14) ^ gm(a2, 11) ^ gm(a3, 13);
                    s[4*c+2] = gm(a0, 13) ^ gm(a1, 9) ^ gm(a2, 14) ^ gm(a3, 11);
                    s[4*c+3] = gm(a0, 11) ^ gm(a1, 13) ^ gm(a2, 9) ^ gm(a3, 14);
                end
            end
        end
        for (int i = 0; i < 16; i++) o[127-8*i -: 8] = s[i];
        return o;
    endfunction

    function automatic void push_res(input logic [127:0] b, input logic [4:0] vb,
                                     input logic eom, input logic [1:0] st);
        res_word_t r;
        r.hi = b[127:64]; r.lo = b[63:0]; r.vb = vb; r.eom = eom; r.st = st;
        expected_res.push_back(r);
    endfunction

    // work out the results of one accepted block
    function automatic void predict_block(input blk_word_t w);
        logic [127:0] b, ct;
        logic [7:0]   n;
        int           cnt;
        bit           extra, ok;
        cnt = (w.cnt > 16) ? 16 : int'(w.cnt);
        if (new_msg) begin
            chain = {iv_hi, iv_lo};
            new_msg = 1'b0;
        end
        b = {w.hi, w.lo};
        if (dir_dec == DIR_ENC) begin
            extra = w.is_last && pad_on && cnt == 16;
            if (cnt < 16 && (!w.is_last || !pad_on)) begin
                push_res('0, 5'd0, 1'b1, ST_PARTIAL);
                new_msg = 1'b1;
                return;
            end
            for (int i = cnt; i < 16; i++) b[127-8*i -: 8] = 8'(16 - cnt);
            b = cipher_fwd(b ^ chain);
            push_res(b, 5'd16, w.is_last && !extra, ST_OK);
            if (w.is_last) new_msg = 1'b1;
            chain = b;
            if (extra) begin
                b = cipher_fwd(b ^ {16{8'h10}});
                push_res(b, 5'd16, 1'b1, ST_OK);
                chain = b;
            end
            return;
        end
        if (cnt != 16) begin
            push_res('0, 5'd0, 1'b1, ST_PART_CT);
            new_msg = 1'b1;
            return;
        end
        ct = b;
        b = cipher_inv(b) ^ chain;
        chain = ct;
        if (w.is_last && pad_on) begin
            n = b[7:0];
            ok = n >= 1 && n <= 16;
            if (ok)
                for (int i = 16 - n; i < 16; i++) if (b[127-8*i -: 8] != n) ok = 0;
            new_msg = 1'b1;
            if (!ok) begin
                push_res('0, 5'd0, 1'b1, ST_BAD_PAD);
                return;
            end
            for (int i = 16 - n; i < 16; i++) b[127-8*i -: 8] = 8'h00;
            push_res(b, 5'(16 - n), 1'b1, ST_OK);
        end else begin
            push_res(b, 5'd16, w.is_last, ST_OK);
            if (w.is_last) new_msg = 1'b1;
        end
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic void queue_word(input logic [63:0] hi, input logic [63:0] lo,
                                       input int cnt, input bit is_last);
        blk_word_t w;
        w.hi = hi; w.lo = lo; w.cnt = 5'(cnt); w.is_last = is_last;
        pending_words.push_back(w);
    endfunction

    // plaintext message, last block of random fill level
    function automatic void queue_plain_msg();
        int nb, c;
        nb = $urandom_range(1, 3);
        for (int k = 0; k < nb; k++) begin
            if (k == nb - 1) begin
                c = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 31) : $urandom_range(0, 16);
                queue_word({$urandom, $urandom}, {$urandom, $urandom}, c, 1);
            end else begin
                c = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 31) : 16;
                queue_word({$urandom, $urandom}, {$urandom, $urandom}, c, 0);
            end
        end
    endfunction

    // well-formed padded ciphertext under the current key and IV, sometimes damaged
    function automatic void queue_cipher_msg(input bit damage);
        logic [127:0] blk [4];
        logic [127:0] ch;
        int len, nb, p;
        len = $urandom_range(0, 47);
        nb = len / 16 + 1;
        p = nb * 16 - len;
        ch = {iv_hi, iv_lo};
        for (int k = 0; k < nb; k++) begin
            blk[k] = {$urandom, $urandom, $urandom, $urandom};
            if (k == nb - 1)
                for (int i = 16 - p; i < 16; i++) blk[k][127-8*i -: 8] = 8'(p);
            blk[k] = cipher_fwd(blk[k] ^ ch);
            ch = blk[k];
        end
        if (damage) blk[nb-1][$urandom_range(0, 127)] ^= 1'b1;
        for (int k = 0; k < nb; k++)
            queue_word(blk[k][127:64], blk[k][63:0], 16, k == nb - 1);
    endfunction

    // drive input words at the falling edge
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (s_taken || !s_tvalid) begin
            s_taken = 0;
            if (s_gap > 0) begin
                s_gap--;
                s_tvalid <= 1'b0;
            end else if (pending_words.size() > 0) begin
                cur_word = pending_words.pop_front();
                s_tdata  <= {3'b000, cur_word.cnt, cur_word.lo, cur_word.hi};
                s_tlast  <= cur_word.is_last;
                s_tvalid <= 1'b1;
                s_gap = pick_gap();
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // predict on each accepted word
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready && !s_taken) begin
            predict_block(cur_word);
            s_taken = 1;
            n_words++;
        end
    end

    // random back-pressure on the result side
    always @(negedge aclk) begin
        if (m_gap > 0) begin
            m_gap--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
            m_gap = pick_gap();
        end
    end

    // check each result word against the oldest expectation
    always @(posedge aclk) begin
        res_word_t e;
        if (aresetn && m_tvalid && m_tready) begin
            n_res++;
            if (expected_res.size() == 0) begin
                $error("unexpected result word");
                n_fail++;
            end else begin
                e = expected_res.pop_front();
                if (m_tdata[63:0] !== e.hi) begin
                    $error("result_high exp %h got %h", e.hi, m_tdata[63:0]);
                    n_fail++;
                end
                if (m_tdata[127:64] !== e.lo) begin
                    $error("result_low exp %h got %h", e.lo, m_tdata[127:64]);
                    n_fail++;
                end
                if (m_tdata[132:128] !== e.vb) begin
                    $error("valid_bytes exp %0d got %0d", e.vb, m_tdata[132:128]);
                    n_fail++;
                end
                if (m_tlast !== e.eom) begin
                    $error("end_of_message exp %0d got %0d", e.eom, m_tlast);
                    n_fail++;
                end
                if (m_tuser !== e.st) begin
                    $error("status exp %0d got %0d", e.st, m_tuser);
                    n_fail++;
                end
            end
        end
    end

    task automatic reg_write(input logic [IDX_W-1:0] idx, input logic [63:0] val);
        @(negedge aclk);
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
        case (idx)
            REG_KEY_HIGH: begin key_hi = val; expand_keys(); end
            REG_KEY_LOW:  begin key_lo = val; expand_keys(); end
            REG_IV_HIGH:  iv_hi = val;
            REG_IV_LOW:   iv_lo = val;
            REG_DIR:      dir_dec = val[0];
            REG_PAD:      pad_on = val[0];
            default: ;
        endcase
    endtask

    // hold until every word is in and every result is out, then let the engine settle
    task automatic drain();
        while (pending_words.size() > 0 || s_tvalid || expected_res.size() > 0)
            @(posedge aclk);
        repeat (30) @(posedge aclk);
        n_phase++;
    endtask

    task automatic set_all(input logic [63:0] kh, input logic [63:0] kl,
                           input logic [63:0] vh, input logic [63:0] vl,
                           input logic dd, input logic pp);
        reg_write(REG_KEY_HIGH, kh);
        reg_write(REG_KEY_LOW, kl);
        reg_write(REG_IV_HIGH, vh);
        reg_write(REG_IV_LOW, vl);
        reg_write(REG_DIR, {63'd0, dd});
        reg_write(REG_PAD, {63'd0, pp});
    endtask

    initial begin
        int nitems;
        aresetn = 1'b0;
        cfg_valid = 1'b0; cfg_index = '0; cfg_data = '0;
        s_tvalid = 1'b0; s_tdata = '0; s_tlast = 1'b0; m_tready = 1'b0;
        s_gap = 0; m_gap = 0; s_taken = 0; calm = 0;
        n_fail = 0; n_words = 0; n_res = 0; n_phase = 0;
        for (int i = 0; i < 256; i++) inv_sb[SBOX[i]] = 8'(i);
        key_hi = '0; key_lo = '0; iv_hi = '0; iv_lo = '0;
        dir_dec = 1'b0; pad_on = 1'b1; new_msg = 1'b1; chain = '0;
        expand_keys();
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // reset settings: fill levels, empty and oversized last blocks
        queue_word('0, '0, 16, 1);
        queue_word('1, '1, 16, 0);
        queue_word('1, '1, 15, 1);
        queue_word('0, '0, 0, 1);
        queue_word(64'h0123456789abcdef, '1, 1, 1);
        queue_word('1, '0, 17, 1);
        queue_word('0, '1, 31, 1);
        queue_word('1, '1, 7, 0);
        queue_word('0, '0, 16, 1);
        drain();

        // all-ones key and IV, padding off: partial blocks are refused
        set_all('1, '1, '1, '1, DIR_ENC, 1'b0);
        queue_word('1, '0, 16, 0);
        queue_word('0, '1, 16, 1);
        queue_word('1, '1, 9, 1);
        queue_word('0, '0, 16, 1);
        drain();

        // decryption with padding: good, damaged, partial ciphertext
        set_all({$urandom, $urandom}, {$urandom, $urandom}, '0, '1, ~DIR_ENC, 1'b1);
        queue_cipher_msg(0);
        queue_cipher_msg(1);
        queue_word('1, '1, 16, 1);
        queue_word('0, '0, 12, 0);
        queue_word('1, '0, 0, 1);
        queue_cipher_msg(0);
        drain();

        // random phases across settings
        for (int ph = 0; ph < 9; ph++) begin
            set_all(ph == 0 ? '0 : {$urandom, $urandom}, {$urandom, $urandom},
                    {$urandom, $urandom}, ph == 1 ? '0 : {$urandom, $urandom},
                    logic'(ph % 2), logic'($urandom_range(0, 3) != 0));
            calm = (ph == 4);
            nitems = 0;
            while (nitems < 90) begin
                if (dir_dec == DIR_ENC) begin
                    queue_plain_msg();
                end else if (pad_on && $urandom_range(0, 9) < 8) begin
                    queue_cipher_msg($urandom_range(0, 7) == 0);
                end else begin
                    queue_word({$urandom, $urandom}, {$urandom, $urandom},
                               ($urandom_range(0, 9) == 0) ? $urandom_range(0, 31) : 16,
                               $urandom_range(0, 2) == 0);
                end
                nitems = pending_words.size();
            end
            drain();
        end

        $display("covered %0d input words, %0d result words over %0d register settings",
                 n_words, n_res, n_phase);
        if (n_fail == 0) begin
            $display("aes128_cbc_engine verification clean");
        end else begin
            $display("aes128_cbc_engine verification failed");
        end
        $finish;
    end

    initial begin
        #8_000_000;
        $display("aes128_cbc_engine verification failed");
        $finish;
    end

endmodule
